### rtl/chrt_pkg.sv
// Package: sizes, codes and record types of the chained hash record table.
package chrt_pkg;

    localparam int BUCKETS = 1000;
    localparam int NODES   = 1024;
    localparam int KEY_W   = 31;
    localparam int CLASS_W = 8;
    localparam int GRADE_W = 16;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(NODES);
    localparam int PTR_W   = $clog2(NODES + 1);
    localparam int CLR_N   = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLR_W   = $clog2(CLR_N);

    // Reciprocal of BUCKETS, rounded up; exact quotient for every key of KEY_W bits.
    localparam int RCP_SHIFT = KEY_W + BKT_W;
    localparam int RCP_W     = KEY_W + 1;
    localparam int PROD_W    = KEY_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((longint'(1) << RCP_SHIFT)
                                       + longint'(BUCKETS) - longint'(1)) / longint'(BUCKETS));

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_WT,
        S_NODE_RD,
        S_NODE_CHK,
        S_ACT
    } state_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_code;
        logic [GRADE_W-1:0] grade_a;
        logic [GRADE_W-1:0] grade_b;
        logic [GRADE_W-1:0] grade_c;
        logic [GRADE_W-1:0] grade_d;
    } payload_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PTR_W-1:0] next;
        payload_t         payload;
    } node_t;

endpackage

### rtl/chained_hash_record_table.sv
// Top level: keyed record table, hashed buckets with chained nodes from a free pool.
// Each transaction computes the bucket remainder, reads the bucket head, then reads
// and compares chain nodes until a match or the chain end, and writes its update.
// Throughput: one transaction at a time; the next is taken once the update is done,
// which waits while an unaccepted result is held. Reset: synchronous, active low;
// a clearing pass empties the bucket heads and fills the free stack; no input meanwhile.
module chained_hash_record_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [chrt_pkg::KEY_W-1:0]      s_key,
    input  logic [chrt_pkg::CLASS_W-1:0]    s_class_in,
    input  logic [chrt_pkg::GRADE_W-1:0]    s_grade_a_in,
    input  logic [chrt_pkg::GRADE_W-1:0]    s_grade_b_in,
    input  logic [chrt_pkg::GRADE_W-1:0]    s_grade_c_in,
    input  logic [chrt_pkg::GRADE_W-1:0]    s_grade_d_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [chrt_pkg::CLASS_W-1:0]    m_class_out,
    output logic [chrt_pkg::GRADE_W-1:0]    m_grade_a_out,
    output logic [chrt_pkg::GRADE_W-1:0]    m_grade_b_out,
    output logic [chrt_pkg::GRADE_W-1:0]    m_grade_c_out,
    output logic [chrt_pkg::GRADE_W-1:0]    m_grade_d_out
);

    logic [chrt_pkg::PTR_W-1:0]  bucket_mem [chrt_pkg::BUCKETS];
    logic [chrt_pkg::NODE_W-1:0] free_mem   [chrt_pkg::NODES];
    chrt_pkg::node_t             node_mem   [chrt_pkg::NODES];

    chrt_pkg::state_t             state_reg, state_next;
    logic [chrt_pkg::CLR_W-1:0]   clr_reg, clr_next;
    chrt_pkg::cmd_t               cmd_reg, cmd_next;
    logic [chrt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [chrt_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [chrt_pkg::BKT_W-1:0]   rem_reg, rem_next;
    chrt_pkg::payload_t           pay_reg, pay_next;
    logic [chrt_pkg::PTR_W-1:0]   cur_reg, cur_next;
    logic [chrt_pkg::PTR_W-1:0]   prev_reg, prev_next;
    chrt_pkg::node_t              prev_word_reg, prev_word_next;
    logic                         found_reg, found_next;
    logic [chrt_pkg::PTR_W-1:0]   free_cnt_reg, free_cnt_next;
    logic                         m_valid_reg, m_valid_next;
    chrt_pkg::status_t            status_reg, status_next;
    chrt_pkg::payload_t           out_reg, out_next;

    logic                         bucket_re, bucket_we;
    logic [chrt_pkg::BKT_W-1:0]   bucket_addr;
    logic [chrt_pkg::PTR_W-1:0]   bucket_wd, bucket_q;
    logic                         free_re, free_we;
    logic [chrt_pkg::NODE_W-1:0]  free_addr, free_wd, free_q;
    logic                         node_re, node_we;
    logic [chrt_pkg::NODE_W-1:0]  node_addr;
    chrt_pkg::node_t              node_wd, node_q;

    logic [chrt_pkg::BKT_W-1:0]   quo_lo;
    logic [chrt_pkg::PTR_W-1:0]   free_dec;
    logic                         out_free;

    always_ff @(posedge aclk) begin
        if (bucket_we) begin
            bucket_mem[bucket_addr] <= bucket_wd;
        end
        if (bucket_re) begin
            bucket_q <= bucket_mem[bucket_addr];
        end
        if (free_we) begin
            free_mem[free_addr] <= free_wd;
        end
        if (free_re) begin
            free_q <= free_mem[free_addr];
        end
        if (node_we) begin
            node_mem[node_addr] <= node_wd;
        end
        if (node_re) begin
            node_q <= node_mem[node_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= chrt_pkg::S_CLEAR;
            clr_reg      <= '0;
            free_cnt_reg <= chrt_pkg::NIL;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_cnt_reg <= free_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        pay_reg       <= pay_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_word_reg <= prev_word_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    assign quo_lo   = prod_reg[chrt_pkg::RCP_SHIFT +: chrt_pkg::BKT_W];
    assign free_dec = free_cnt_reg - chrt_pkg::PTR_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        pay_next       = pay_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_word_next = prev_word_reg;
        found_next     = found_reg;
        free_cnt_next  = free_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        out_next       = out_reg;
        s_ready        = 1'b0;
        bucket_re      = 1'b0;
        bucket_we      = 1'b0;
        bucket_addr    = rem_reg;
        bucket_wd      = chrt_pkg::NIL;
        free_re        = 1'b0;
        free_we        = 1'b0;
        free_addr      = free_dec[chrt_pkg::NODE_W-1:0];
        free_wd        = '0;
        node_re        = 1'b0;
        node_we        = 1'b0;
        node_addr      = cur_reg[chrt_pkg::NODE_W-1:0];
        node_wd        = node_q;

        unique case (state_reg)
            chrt_pkg::S_CLEAR: begin
                bucket_addr = clr_reg[chrt_pkg::BKT_W-1:0];
                bucket_we   = 32'(clr_reg) < chrt_pkg::BUCKETS;
                free_addr   = clr_reg[chrt_pkg::NODE_W-1:0];
                free_we     = 32'(clr_reg) < chrt_pkg::NODES;
                free_wd     = chrt_pkg::NODE_W'(chrt_pkg::NODES - 1)
                              - clr_reg[chrt_pkg::NODE_W-1:0];
                clr_next    = clr_reg + chrt_pkg::CLR_W'(1);
                if (32'(clr_reg) == chrt_pkg::CLR_N - 1) begin
                    state_next = chrt_pkg::S_IDLE;
                end
            end
            chrt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = chrt_pkg::cmd_t'(s_cmd);
                    key_next   = s_key;
                    prod_next  = chrt_pkg::PROD_W'(s_key) * chrt_pkg::PROD_W'(chrt_pkg::RCP);
                    pay_next   = '{s_class_in, s_grade_a_in, s_grade_b_in,
                                   s_grade_c_in, s_grade_d_in};
                    state_next = chrt_pkg::S_MOD;
                end
            end
            chrt_pkg::S_MOD: begin
                rem_next   = key_reg[chrt_pkg::BKT_W-1:0]
                             - quo_lo * chrt_pkg::BKT_W'(chrt_pkg::BUCKETS);
                state_next = chrt_pkg::S_HEAD_RD;
            end
            chrt_pkg::S_HEAD_RD: begin
                bucket_re  = 1'b1;
                free_re    = 1'b1;
                state_next = chrt_pkg::S_HEAD_WT;
            end
            chrt_pkg::S_HEAD_WT: begin
                cur_next   = bucket_q;
                prev_next  = chrt_pkg::NIL;
                state_next = chrt_pkg::S_NODE_RD;
            end
            chrt_pkg::S_NODE_RD: begin
                if (cur_reg >= chrt_pkg::NIL) begin
                    found_next = 1'b0;
                    state_next = chrt_pkg::S_ACT;
                end else begin
                    node_re    = 1'b1;
                    state_next = chrt_pkg::S_NODE_CHK;
                end
            end
            chrt_pkg::S_NODE_CHK: begin
                if (node_q.key == key_reg) begin
                    found_next = 1'b1;
                    state_next = chrt_pkg::S_ACT;
                end else begin
                    prev_next      = cur_reg;
                    prev_word_next = node_q;
                    cur_next       = node_q.next;
                    state_next     = chrt_pkg::S_NODE_RD;
                end
            end
            chrt_pkg::S_ACT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = chrt_pkg::S_IDLE;
                    status_next  = found_reg ? chrt_pkg::ST_OK : chrt_pkg::ST_NOT_FOUND;
                    out_next     = found_reg ? node_q.payload : '0;
                    case (cmd_reg)
                        chrt_pkg::CMD_INSERT: begin
                            if (found_reg) begin
                                status_next = chrt_pkg::ST_DUPLICATE;
                            end else if (free_cnt_reg == '0) begin
                                status_next = chrt_pkg::ST_FULL;
                            end else begin
                                status_next   = chrt_pkg::ST_OK;
                                out_next      = pay_reg;
                                node_we       = 1'b1;
                                node_addr     = free_q;
                                node_wd       = '{key_reg, bucket_q, pay_reg};
                                bucket_we     = 1'b1;
                                bucket_wd     = {1'b0, free_q};
                                free_cnt_next = free_dec;
                            end
                        end
                        chrt_pkg::CMD_MODIFY: begin
                            if (found_reg) begin
                                out_next        = pay_reg;
                                node_we         = 1'b1;
                                node_wd.payload = pay_reg;
                            end
                        end
                        chrt_pkg::CMD_DELETE: begin
                            if (found_reg) begin
                                if (prev_reg >= chrt_pkg::NIL) begin
                                    bucket_we = 1'b1;
                                    bucket_wd = node_q.next;
                                end else begin
                                    node_we      = 1'b1;
                                    node_addr    = prev_reg[chrt_pkg::NODE_W-1:0];
                                    node_wd      = prev_word_reg;
                                    node_wd.next = node_q.next;
                                end
                                if (free_cnt_reg < chrt_pkg::NIL) begin
                                    free_we       = 1'b1;
                                    free_addr     = free_cnt_reg[chrt_pkg::NODE_W-1:0];
                                    free_wd       = cur_reg[chrt_pkg::NODE_W-1:0];
                                    free_cnt_next = free_cnt_reg + chrt_pkg::PTR_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = chrt_pkg::S_CLEAR;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_class_out   = out_reg.class_code;
    assign m_grade_a_out = out_reg.grade_a;
    assign m_grade_b_out = out_reg.grade_b;
    assign m_grade_c_out = out_reg.grade_c;
    assign m_grade_d_out = out_reg.grade_d;

endmodule

### rtl/chrt_checker.sv
// Checker: port-level properties of the record table, bound to the top level.
module chrt_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [1:0]                   m_status,
    input logic [chrt_pkg::CLASS_W-1:0] m_class_out,
    input logic [chrt_pkg::GRADE_W-1:0] m_grade_a_out,
    input logic [chrt_pkg::GRADE_W-1:0] m_grade_b_out,
    input logic [chrt_pkg::GRADE_W-1:0] m_grade_c_out,
    input logic [chrt_pkg::GRADE_W-1:0] m_grade_d_out
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction taken while another is in flight");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == chrt_pkg::ST_NOT_FOUND || m_status == chrt_pkg::ST_FULL)
        |-> m_class_out == '0 && m_grade_a_out == '0 && m_grade_b_out == '0
            && m_grade_c_out == '0 && m_grade_d_out == '0)
        else $error("record fields not zero on a miss");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_class_out))
        else $error("stalled result changed");

endmodule

bind chained_hash_record_table chrt_checker u_chrt_checker (.*);

### sim/testbench.sv
// Testbench for chained_hash_record_table: directed and random commands against a table model.

class record_table_scoreboard;
    int                     bucket_head[chrt_pkg::BUCKETS];
    logic [30:0]            node_key[chrt_pkg::NODES];
    int                     node_next[chrt_pkg::NODES];
    chrt_pkg::payload_t     node_data[chrt_pkg::NODES];
    int                     free_stack[chrt_pkg::NODES];
    int                     free_count;
    chrt_pkg::status_t      exp_status[$];
    chrt_pkg::payload_t     exp_data[$];
    int                     errors;
    int                     live_keys[$];

    function new();
        for (int i = 0; i < chrt_pkg::BUCKETS; i++) bucket_head[i] = chrt_pkg::NODES;
        for (int i = 0; i < chrt_pkg::NODES; i++) begin
            node_next[i] = chrt_pkg::NODES;
            free_stack[i] = chrt_pkg::NODES - 1 - i;
        end
        free_count = chrt_pkg::NODES;
        errors = 0;
    endfunction

    function void note_command(chrt_pkg::cmd_t cmd, logic [30:0] key,
                               chrt_pkg::payload_t din);
        int bkt;
        int cur;
        int prv;
        int fresh;
        chrt_pkg::status_t st;
        chrt_pkg::payload_t res;
        bkt = int'(key) % chrt_pkg::BUCKETS;
        cur = bucket_head[bkt];
        prv = chrt_pkg::NODES;
        while (cur < chrt_pkg::NODES && node_key[cur] != key) begin
            prv = cur;
            cur = node_next[cur];
        end
        res = '0;
        case (cmd)
            chrt_pkg::CMD_LOOKUP: begin
                st = (cur < chrt_pkg::NODES) ? chrt_pkg::ST_OK : chrt_pkg::ST_NOT_FOUND;
                if (cur < chrt_pkg::NODES) res = node_data[cur];
            end
            chrt_pkg::CMD_INSERT: begin
                if (cur < chrt_pkg::NODES) begin
                    st = chrt_pkg::ST_DUPLICATE;
                    res = node_data[cur];
                end else if (free_count == 0) begin
                    st = chrt_pkg::ST_FULL;
                end else begin
                    free_count--;
                    fresh = free_stack[free_count];
                    node_key[fresh] = key;
                    node_data[fresh] = din;
                    node_next[fresh] = bucket_head[bkt];
                    bucket_head[bkt] = fresh;
                    st = chrt_pkg::ST_OK;
                    res = din;
                    live_keys.push_back(int'(key));
                end
            end
            chrt_pkg::CMD_MODIFY: begin
                st = (cur < chrt_pkg::NODES) ? chrt_pkg::ST_OK : chrt_pkg::ST_NOT_FOUND;
                if (cur < chrt_pkg::NODES) begin
                    node_data[cur] = din;
                    res = din;
                end
            end
            default: begin
                st = (cur < chrt_pkg::NODES) ? chrt_pkg::ST_OK : chrt_pkg::ST_NOT_FOUND;
                if (cur < chrt_pkg::NODES) begin
                    res = node_data[cur];
                    if (prv < chrt_pkg::NODES) node_next[prv] = node_next[cur];
                    else bucket_head[bkt] = node_next[cur];
                    node_next[cur] = chrt_pkg::NODES;
                    free_stack[free_count] = cur;
                    free_count++;
                    foreach (live_keys[i]) if (31'(live_keys[i]) == key) begin
                        live_keys.delete(i);
                        break;
                    end
                end
            end
        endcase
        exp_status.push_back(st);
        exp_data.push_back(res);
    endfunction

    function void check_result(chrt_pkg::status_t st, chrt_pkg::payload_t got);
        chrt_pkg::payload_t w;
        if (exp_status.size() == 0) begin
            $error("unexpected result status %0d", st);
            errors++;
            return;
        end
        w = exp_data.pop_front();
        if (exp_status[0] != st) begin
            $error("status expected %0d actual %0d", exp_status[0], st);
            errors++;
        end
        void'(exp_status.pop_front());
        if (w.class_code != got.class_code) begin
            $error("class_out expected %0h actual %0h", w.class_code, got.class_code);
            errors++;
        end
        if (w.grade_a != got.grade_a) begin
            $error("grade_a_out expected %0h actual %0h", w.grade_a, got.grade_a);
            errors++;
        end
        if (w.grade_b != got.grade_b) begin
            $error("grade_b_out expected %0h actual %0h", w.grade_b, got.grade_b);
            errors++;
        end
        if (w.grade_c != got.grade_c) begin
            $error("grade_c_out expected %0h actual %0h", w.grade_c, got.grade_c);
            errors++;
        end
        if (w.grade_d != got.grade_d) begin
            $error("grade_d_out expected %0h actual %0h", w.grade_d, got.grade_d);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_cmd = '0;
    logic [chrt_pkg::KEY_W-1:0] s_key = '0;
    logic [7:0]                 s_class_in = '0;
    logic [15:0]                s_grade_a_in = '0;
    logic [15:0]                s_grade_b_in = '0;
    logic [15:0]                s_grade_c_in = '0;
    logic [15:0]                s_grade_d_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [1:0]                 m_status;
    logic [7:0]                 m_class_out;
    logic [15:0]                m_grade_a_out;
    logic [15:0]                m_grade_b_out;
    logic [15:0]                m_grade_c_out;
    logic [15:0]                m_grade_d_out;

    record_table_scoreboard table_model = new();
    int idle_cycles = 0;

    chained_hash_record_table dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 6000) begin
            $display("chained_hash_record_table test failed");
            $finish;
        end
    end

    task automatic send_command(chrt_pkg::cmd_t cmd, logic [30:0] key,
                                chrt_pkg::payload_t din);
        int gap;
        gap = $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_key <= key;
        s_class_in <= din.class_code;
        s_grade_a_in <= din.grade_a;
        s_grade_b_in <= din.grade_b;
        s_grade_c_in <= din.grade_c;
        s_grade_d_in <= din.grade_d;
        do @(posedge aclk); while (!s_ready);
        table_model.note_command(cmd, key, din);
    endtask

    function automatic chrt_pkg::payload_t random_payload();
        chrt_pkg::payload_t p;
        p = 72'({$urandom, $urandom, $urandom});
        return p;
    endfunction

    function automatic logic [30:0] pick_key(int kind);
        int n;
        n = table_model.live_keys.size();
        if (kind < 45 && n > 0) return 31'(table_model.live_keys[$urandom_range(0, n - 1)]);
        if (kind < 75) return 31'($urandom_range(0, 7) * 1000 + $urandom_range(0, 3));
        return 31'($urandom);
    endfunction

    initial begin
        bit stretch;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                table_model.check_result(chrt_pkg::status_t'(m_status),
                    {m_class_out, m_grade_a_out, m_grade_b_out, m_grade_c_out,
                     m_grade_d_out});
                stretch = ($urandom_range(0, 3) == 0);
                if (stretch) m_ready <= 1'b0;
            end else if (!m_ready && (stretch || $urandom_range(0, 18) == 0)) begin
                m_ready <= 1'b1;
            end else if (!m_ready) begin
                m_ready <= ($urandom_range(0, 9) == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        chrt_pkg::payload_t hi;
        chrt_pkg::payload_t lo;
        logic [30:0] k;
        hi = '1;
        lo = '0;
        @(posedge aclk iff aresetn);
        send_command(chrt_pkg::CMD_DELETE, 31'd5, lo);
        send_command(chrt_pkg::CMD_LOOKUP, 31'h7fffffff, lo);
        send_command(chrt_pkg::CMD_MODIFY, 31'd0, hi);
        send_command(chrt_pkg::CMD_INSERT, 31'd0, lo);
        send_command(chrt_pkg::CMD_INSERT, 31'h7fffffff, hi);
        send_command(chrt_pkg::CMD_INSERT, 31'd1000, hi);
        send_command(chrt_pkg::CMD_INSERT, 31'd2000, random_payload());
        send_command(chrt_pkg::CMD_INSERT, 31'd1000, lo);
        send_command(chrt_pkg::CMD_LOOKUP, 31'd0, lo);
        send_command(chrt_pkg::CMD_MODIFY, 31'd1000, random_payload());
        send_command(chrt_pkg::CMD_LOOKUP, 31'd1000, lo);
        send_command(chrt_pkg::CMD_DELETE, 31'd1000, lo);
        send_command(chrt_pkg::CMD_LOOKUP, 31'd2000, lo);
        send_command(chrt_pkg::CMD_DELETE, 31'd0, lo);
        send_command(chrt_pkg::CMD_DELETE, 31'd2000, lo);
        send_command(chrt_pkg::CMD_LOOKUP, 31'h7fffffff, lo);
        send_command(chrt_pkg::CMD_DELETE, 31'h7fffffff, lo);
        for (int i = 0; i < 1030; i++) begin
            k = 31'(i * 7 + 100);
            if (i == 700) send_command(chrt_pkg::CMD_LOOKUP, pick_key(0), lo);
            send_command(chrt_pkg::CMD_INSERT, k, random_payload());
        end
        for (int i = 0; i < 6; i++)
            send_command(chrt_pkg::cmd_t'($urandom_range(0, 3)),
                pick_key($urandom_range(0, 99)), random_payload());
        s_valid <= 1'b0;
        while (table_model.exp_status.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (table_model.errors == 0) $display("chained_hash_record_table test passed");
        else $display("chained_hash_record_table test failed");
        $finish;
    end
endmodule
